>>> hw/rtl/ppm_fs_pkg.sv
// ----------------------------------------------------------------------------
// ppm_fs_pkg
// Types, constants and codes shared by the PPM frame sequencer files.
// ----------------------------------------------------------------------------
package ppm_fs_pkg;

  localparam int NUM_CHANNELS = 16;

  // Field widths of the channels and registers.
  localparam int KindW    = 2;
  localparam int SelW     = 5;
  localparam int ValueW   = 12;
  localparam int PeriodW  = 16;
  localparam int CmpW     = 12;
  localparam int OutIdxW  = 4;
  localparam int ActW     = 5;
  localparam int SlotW    = 12;
  localparam int SyncW    = 13;
  localparam int PulseW   = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam int ChanIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CountW   = $clog2(NUM_CHANNELS + 1);
  localparam int CmpCntW  = ((CountW > ActW) ? CountW : ActW) + 1;
  localparam int SelCmpW  = ((SelW > CountW) ? SelW : CountW) + 1;
  localparam int FrameW   = $clog2(4095 * NUM_CHANNELS + 8191 + 1);
  localparam int SumW     = PeriodW + 1;

  localparam logic [ValueW-1:0]  VALUE_FLOOR = ValueW'(800);
  localparam logic [ValueW-1:0]  RESET_VALUE = ValueW'(1500);
  localparam logic [PeriodW-1:0] PERIOD_MAX  = {PeriodW{1'b1}};

  localparam logic [ActW-1:0]   ACT_RESET   = ActW'(8);
  localparam logic [SlotW-1:0]  SLOT_RESET  = SlotW'(2200);
  localparam logic [SyncW-1:0]  SYNC_RESET  = SyncW'(4500);
  localparam logic [PulseW-1:0] PULSE_RESET = PulseW'(300);

  typedef enum logic [KindW-1:0] {
    KIND_SET     = 2'd0,
    KIND_START   = 2'd1,
    KIND_ELAPSED = 2'd2,
    KIND_STOP    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE = 2'd0,
    CFG_SLOT   = 2'd1,
    CFG_SYNC   = 2'd2,
    CFG_PULSE  = 2'd3
  } cfg_idx_e;

  // Work left for the second stage.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_START = 2'd1,
    OP_CHAN  = 2'd2,
    OP_GAP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              clr;   // frame total restarts before this word
    logic [CountW-1:0] idx;
  } stage_t;

  typedef struct packed {
    logic                we;
    logic [ChanIdxW-1:0] waddr;
    logic [ValueW-1:0]   wdata;
    logic                re;
    logic [ChanIdxW-1:0] raddr;
  } table_req_t;

endpackage

>>> hw/rtl/ppm_fs_if.sv
// ----------------------------------------------------------------------------
// ppm_fs_if
// Valid/ready channels for event words in and period words out.
// ----------------------------------------------------------------------------
interface ppm_fs_in_if
  import ppm_fs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [SelW-1:0]   channel_select;
  logic [ValueW-1:0] channel_value;

  modport source (output valid, kind, channel_select, channel_value, input ready);
  modport sink   (input valid, kind, channel_select, channel_value, output ready);
endinterface

interface ppm_fs_out_if
  import ppm_fs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PeriodW-1:0] period_length;
  logic [CmpW-1:0]    compare_value;
  logic               is_sync;
  logic [OutIdxW-1:0] channel_index;

  modport source (output valid, period_length, compare_value, is_sync, channel_index,
                  input ready);
  modport sink   (input valid, period_length, compare_value, is_sync, channel_index,
                  output ready);
endinterface

>>> hw/rtl/ppm_frame_sequencer.sv
// ----------------------------------------------------------------------------
// ppm_frame_sequencer
// PPM frame sequencer: channel period table, frame stepping and gap timing.
// ----------------------------------------------------------------------------
// A new event word may be taken in every cycle. A period word passes through
// the second-stage register and then the output register before it is valid
// at the output. The input stalls only while both the second stage and the
// output register hold words that the receiver has not yet taken.
// The first stage steps the channel pointer and issues the table read, the
// second stage uses the registered read data to update the frame total and
// form the period word, and an output register holds it until it is taken.
// The channel periods live in a small synchronous memory whose entries read
// as 1500 until first written, so no clearing pass follows reset. Frame time
// is recomputed from the registers every cycle, so registers must be written
// only while the block is idle.
module ppm_frame_sequencer
  import ppm_fs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ppm_fs_in_if.sink           in_i,
  ppm_fs_out_if.source        out_o
);

  logic [ActW-1:0]    act_q;
  logic [SlotW-1:0]   slot_q;
  logic [SyncW-1:0]   sync_q;
  logic [PulseW-1:0]  pulse_q;
  logic [CountW-1:0]  count;
  logic [FrameW-1:0]  frame_q, frame_d;
  logic               accept;
  logic               stage_free;
  stage_t             stage;
  table_req_t         req;
  logic [ValueW-1:0]  rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= ACT_RESET;
      slot_q  <= SLOT_RESET;
      sync_q  <= SYNC_RESET;
      pulse_q <= PULSE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE: act_q   <= cfg_data_i[ActW-1:0];
        CFG_SLOT:   slot_q  <= cfg_data_i[SlotW-1:0];
        CFG_SYNC:   sync_q  <= cfg_data_i[SyncW-1:0];
        CFG_PULSE:  pulse_q <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // Active count saturated at the table size, and the nominal frame time.
  assign count   = (CmpCntW'(act_q) > CmpCntW'(NUM_CHANNELS)) ?
                   CountW'(NUM_CHANNELS) : CountW'(act_q);
  assign frame_d = FrameW'(FrameW'(slot_q) * FrameW'(count)) + FrameW'(sync_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else begin
      frame_q <= frame_d;
    end
  end

  ppm_fs_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .stage_free_i (stage_free),
    .slot_i       (slot_q),
    .count_i      (count),
    .accept_o     (accept),
    .stage_o      (stage),
    .req_o        (req)
  );

  ppm_fs_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  ppm_fs_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .stage_i      (stage),
    .rd_data_i    (rd_data),
    .frame_i      (frame_q),
    .sync_i       (sync_q),
    .pulse_i      (pulse_q),
    .stage_free_o (stage_free),
    .out_o        (out_o)
  );

`ifndef ASSERT_OFF
  // The input only stalls behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_free |-> out_o.valid)
    else $error("input stalled with an empty output register");

  // A channel slot word always names a channel within the active count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_sync) |-> (CountW'(out_o.channel_index) < count))
    else $error("channel word beyond the active count");

  // A start always leaves a result for the second stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_e'(in_i.kind) == KIND_START)) |-> (stage.op == OP_START))
    else $error("start event decoded without a result");

  // Table reads are issued only for channel slot words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.re |-> (accept && (stage.op == OP_CHAN)))
    else $error("table read without a channel slot word");
`endif

endmodule

>>> hw/rtl/ppm_fs_table.sv
// ----------------------------------------------------------------------------
// ppm_fs_table
// Channel period memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ppm_fs_table
  import ppm_fs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  table_req_t        req_i,
  output logic [ValueW-1:0] rd_data_o
);

  logic [ValueW-1:0]       mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_q;
  logic [ValueW-1:0]       rd_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  // An entry never written reads as the reset period.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : RESET_VALUE;

endmodule

>>> hw/rtl/ppm_fs_seq.sv
// ----------------------------------------------------------------------------
// ppm_fs_seq
// First stage: decodes event words, steps the channel pointer and drives
// the table.
// ----------------------------------------------------------------------------
module ppm_fs_seq
  import ppm_fs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ppm_fs_in_if.sink         in_i,
  input  logic              stage_free_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [CountW-1:0] count_i,
  output logic              accept_o,
  output stage_t            stage_o,
  output table_req_t        req_o
);

  logic [CountW-1:0] next_ch_q, next_ch_d;
  logic              in_sync_q, in_sync_d;
  logic              running_q, running_d;
  logic [CountW-1:0] cur_ch;
  logic              sel_ok;
  kind_e             kind;

  assign in_i.ready = stage_free_i;
  assign accept_o   = in_i.valid && in_i.ready;
  assign kind       = kind_e'(in_i.kind);
  assign cur_ch     = in_sync_q ? '0 : next_ch_q;
  assign sel_ok     = SelCmpW'(in_i.channel_select) < SelCmpW'(NUM_CHANNELS);

  always_comb begin
    next_ch_d     = next_ch_q;
    in_sync_d     = in_sync_q;
    running_d     = running_q;
    stage_o.op    = OP_NONE;
    stage_o.clr   = 1'b0;
    stage_o.idx   = cur_ch;
    req_o.we      = 1'b0;
    req_o.waddr   = in_i.channel_select[ChanIdxW-1:0];
    req_o.wdata   = in_i.channel_value;
    req_o.re      = 1'b0;
    req_o.raddr   = cur_ch[ChanIdxW-1:0];
    if (accept_o) begin
      unique case (kind)
        KIND_SET: begin
          req_o.we = sel_ok && (in_i.channel_value > VALUE_FLOOR) &&
                     (in_i.channel_value < slot_i);
        end
        KIND_START: begin
          next_ch_d  = '0;
          in_sync_d  = 1'b1;
          running_d  = 1'b1;
          stage_o.op = OP_START;
        end
        KIND_STOP: begin
          running_d = 1'b0;
        end
        KIND_ELAPSED: begin
          if (running_q) begin
            stage_o.clr = in_sync_q;
            if (cur_ch < count_i) begin
              stage_o.op = OP_CHAN;
              req_o.re   = 1'b1;
              next_ch_d  = cur_ch + CountW'(1);
              in_sync_d  = 1'b0;
            end else begin
              stage_o.op = OP_GAP;
              next_ch_d  = cur_ch;
              in_sync_d  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_ch_q <= '0;
      in_sync_q <= 1'b0;
      running_q <= 1'b0;
    end else begin
      next_ch_q <= next_ch_d;
      in_sync_q <= in_sync_d;
      running_q <= running_d;
    end
  end

endmodule

>>> hw/rtl/ppm_fs_out.sv
// ----------------------------------------------------------------------------
// ppm_fs_out
// Second stage: keeps the frame total, forms the period word and holds it
// in the output register.
// ----------------------------------------------------------------------------
module ppm_fs_out
  import ppm_fs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  stage_t            stage_i,
  input  logic [ValueW-1:0] rd_data_i,
  input  logic [FrameW-1:0] frame_i,
  input  logic [SyncW-1:0]  sync_i,
  input  logic [PulseW-1:0] pulse_i,
  output logic              stage_free_o,
  ppm_fs_out_if.source      out_o
);

  logic               s1_v_q, s1_v_d;
  stage_t             s1_q;
  logic               s1_adv;
  logic               s1_load;
  logic [PeriodW-1:0] elapsed_q, elapsed_d;
  logic [PeriodW-1:0] base;
  logic [SumW-1:0]    sum;
  logic [FrameW-1:0]  gap;
  logic               out_v_q, out_v_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [CmpW-1:0]    cmp_q, cmp_d;
  logic               sync_q, sync_d;
  logic [OutIdxW-1:0] idx_q, idx_d;

  assign s1_adv       = !out_v_q || out_o.ready;
  assign stage_free_o = !s1_v_q || s1_adv;
  assign s1_load      = accept_i && (stage_i.op != OP_NONE);
  assign s1_v_d       = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_v_q);

  assign base = s1_q.clr ? '0 : elapsed_q;
  assign sum  = SumW'(base) + SumW'(rd_data_i);
  assign gap  = (frame_i > FrameW'(base)) ? (frame_i - FrameW'(base)) : '0;

  always_comb begin
    elapsed_d = elapsed_q;
    out_v_d   = out_v_q && !out_o.ready;
    period_d  = period_q;
    cmp_d     = cmp_q;
    sync_d    = sync_q;
    idx_d     = idx_q;
    if (s1_v_q && s1_adv) begin
      out_v_d = 1'b1;
      unique case (s1_q.op)
        OP_START: begin
          elapsed_d = '0;
          period_d  = PeriodW'(sync_i);
          cmp_d     = '0;
          sync_d    = 1'b1;
          idx_d     = '0;
        end
        OP_CHAN: begin
          elapsed_d = sum[PeriodW] ? PERIOD_MAX : sum[PeriodW-1:0];
          period_d  = PeriodW'(rd_data_i);
          cmp_d     = CmpW'(pulse_i);
          sync_d    = 1'b0;
          idx_d     = OutIdxW'(s1_q.idx);
        end
        OP_GAP: begin
          elapsed_d = base;
          period_d  = (gap > FrameW'(PERIOD_MAX)) ? PERIOD_MAX : gap[PeriodW-1:0];
          cmp_d     = CmpW'(pulse_i);
          sync_d    = 1'b1;
          idx_d     = '0;
        end
        default: begin
          out_v_d = out_v_q && !out_o.ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      elapsed_q <= '0;
    end else begin
      s1_v_q    <= s1_v_d;
      out_v_q   <= out_v_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= stage_i;
    end
    period_q <= period_d;
    cmp_q    <= cmp_d;
    sync_q   <= sync_d;
    idx_q    <= idx_d;
  end

  assign out_o.valid         = out_v_q;
  assign out_o.period_length = period_q;
  assign out_o.compare_value = cmp_q;
  assign out_o.is_sync       = sync_q;
  assign out_o.channel_index = idx_q;

endmodule

>>> dv/ppm_frame_sequencer_test.sv
// ----------------------------------------------------------------------------
// ppm_frame_sequencer_test
// Self-checking bench for the PPM frame sequencer. A short table of directed
// event words covers start, stop, channel writes at the value bounds, ignored
// slots, a zero channel count and an underflowing closing gap. It is followed
// by phases of random frames under varied register settings. Every period
// word is checked field by field against the table or the frame predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppm_frame_sequencer_test;
  import ppm_fs_pkg::*;

  localparam int SETTLE_CYCLES   = 4;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_PHASE      = 3;

  typedef struct packed {
    logic [PeriodW-1:0] period_length;
    logic [CmpW-1:0]    compare_value;
    logic               is_sync;
    logic [OutIdxW-1:0] channel_index;
  } period_t;

  typedef struct {
    bit       reg_write;
    cfg_idx_e reg_idx;
    int       reg_data;
    kind_e    kind;
    int       sel;
    int       val;
    bit       typed;
    period_t  word;
  } step_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ppm_fs_in_if  in_if ();
  ppm_fs_out_if out_if ();

  ppm_frame_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Frame predictor state and its copy of the registers.
  logic [ValueW-1:0] chan_period [NUM_CHANNELS];
  int                next_slot;
  int                frame_total;
  bit                gap_pending;
  bit                seq_running;
  logic [ActW-1:0]   act_count;
  logic [SlotW-1:0]  slot_len;
  logic [SyncW-1:0]  sync_len;
  logic [PulseW-1:0] pulse_w;

  period_t pending_periods [$];
  int      error_count;
  bit      idle_on;
  bit      hold_req;
  bit      typed_armed;
  period_t typed_word;
  step_t   steps [$];

  function automatic period_t mk_word(int p, int c, bit s, int i);
    period_t w;
    w.period_length = p[PeriodW-1:0];
    w.compare_value = c[CmpW-1:0];
    w.is_sync       = s;
    w.channel_index = i[OutIdxW-1:0];
    return w;
  endfunction

  // Works out the period word caused by one event word, if any.
  function automatic bit predict_period(input kind_e k, input logic [SelW-1:0] sel,
                                        input logic [ValueW-1:0] val, output period_t w);
    int cnt;
    int frame;
    int gap;
    w = '0;
    case (k)
      KIND_SET: begin
        if (sel < NUM_CHANNELS && val > VALUE_FLOOR && val < slot_len)
          chan_period[sel[ChanIdxW-1:0]] = val;
        return 1'b0;
      end
      KIND_START: begin
        next_slot   = 0;
        frame_total = 0;
        gap_pending = 1'b1;
        seq_running = 1'b1;
        w = mk_word(int'(sync_len), 0, 1'b1, 0);
        return 1'b1;
      end
      KIND_STOP: begin
        seq_running = 1'b0;
        return 1'b0;
      end
      default: ;
    endcase
    if (!seq_running) return 1'b0;
    if (gap_pending) begin
      gap_pending = 1'b0;
      next_slot   = 0;
      frame_total = 0;
    end
    cnt = (int'(act_count) > NUM_CHANNELS) ? NUM_CHANNELS : int'(act_count);
    if (next_slot < cnt) begin
      frame_total += int'(chan_period[next_slot]);
      if (frame_total > 65535) frame_total = 65535;
      w = mk_word(int'(chan_period[next_slot]), int'(pulse_w), 1'b0, next_slot);
      next_slot++;
      return 1'b1;
    end
    // All active channels sent: close the frame with the remaining gap.
    gap_pending = 1'b1;
    frame = int'(slot_len) * cnt + int'(sync_len);
    gap   = (frame > frame_total) ? frame - frame_total : 0;
    if (gap > 65535) gap = 65535;
    w = mk_word(gap, int'(pulse_w), 1'b1, 0);
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      error_count++;
    end
  endtask

  // Results are checked before the event word of the same edge is predicted,
  // since no event can produce its word in the cycle it is taken.
  always @(posedge clk_i) begin : scoreboard
    period_t got;
    period_t exp;
    period_t w;
    if (rst_ni) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got = {out_if.period_length, out_if.compare_value, out_if.is_sync,
               out_if.channel_index};
        if (pending_periods.size() == 0) begin
          $display("%0t: unexpected period word, expected none, got %0d/%0d/%0d/%0d",
                   $time, got.period_length, got.compare_value, got.is_sync,
                   got.channel_index);
          error_count++;
        end else begin
          exp = pending_periods.pop_front();
          check_field("period_length", exp.period_length, got.period_length);
          check_field("compare_value", 16'(exp.compare_value), 16'(got.compare_value));
          check_field("is_sync", 16'(exp.is_sync), 16'(got.is_sync));
          check_field("channel_index", 16'(exp.channel_index), 16'(got.channel_index));
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        if (predict_period(kind_e'(in_if.kind), in_if.channel_select,
                           in_if.channel_value, w))
          pending_periods.push_back(typed_armed ? typed_word : w);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : sink_drive
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(kind_e k, int sel, int val, bit typed, period_t w);
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid          <= 1'b1;
    in_if.kind           <= k;
    in_if.channel_select <= SelW'(sel);
    in_if.channel_value  <= ValueW'(val);
    typed_armed          <= typed;
    typed_word           <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_periods.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(data);
    case (idx)
      CFG_ACTIVE: act_count = data[ActW-1:0];
      CFG_SLOT:   slot_len  = data[SlotW-1:0];
      CFG_SYNC:   sync_len  = data[SyncW-1:0];
      CFG_PULSE:  pulse_w   = data[PulseW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_event(kind_e k, int sel, int val);
    step_t s;
    s = '{reg_write: 1'b0, reg_idx: CFG_ACTIVE, reg_data: 0, kind: k, sel: sel,
          val: val, typed: 1'b0, word: '0};
    steps.push_back(s);
  endtask

  task automatic add_checked(kind_e k, period_t w);
    step_t s;
    s = '{reg_write: 1'b0, reg_idx: CFG_ACTIVE, reg_data: 0, kind: k, sel: 0,
          val: 0, typed: 1'b1, word: w};
    steps.push_back(s);
  endtask

  task automatic add_reg(cfg_idx_e idx, int data);
    step_t s;
    s = '{reg_write: 1'b1, reg_idx: idx, reg_data: data, kind: KIND_SET, sel: 0,
          val: 0, typed: 1'b0, word: '0};
    steps.push_back(s);
  endtask

  task automatic configure_phase(int phase);
    case (phase)
      0: begin
        write_reg(CFG_ACTIVE, NUM_CHANNELS);
        write_reg(CFG_SLOT, 4095);
        write_reg(CFG_SYNC, 8191);
        write_reg(CFG_PULSE, 4095);
      end
      1: begin
        write_reg(CFG_ACTIVE, 0);
        write_reg(CFG_SLOT, 1);
        write_reg(CFG_SYNC, 1);
        write_reg(CFG_PULSE, 0);
      end
      2: begin
        write_reg(CFG_ACTIVE, $urandom_range(NUM_CHANNELS + 1, 31));
        write_reg(CFG_SLOT, $urandom_range(2000, 4095));
        write_reg(CFG_SYNC, $urandom_range(1, 8191));
        write_reg(CFG_PULSE, $urandom_range(0, 4095));
      end
      default: begin
        if ($urandom_range(0, 1))
          write_reg(CFG_ACTIVE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 10));
        if ($urandom_range(0, 1))
          write_reg(CFG_SLOT, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 900)
                                                          : $urandom_range(801, 4095));
        if ($urandom_range(0, 1)) write_reg(CFG_SYNC, $urandom_range(1, 8191));
        if ($urandom_range(0, 1)) write_reg(CFG_PULSE, $urandom_range(0, 4095));
      end
    endcase
  endtask

  // Mostly well-formed frames: start, then period-elapsed events, with
  // channel writes, restarts and stops mixed in.
  task automatic random_event(output kind_e k, output int sel, output int val);
    int r;
    r = $urandom_range(0, 99);
    if (!seq_running)
      k = (r < 60) ? KIND_START : (r < 72) ? KIND_ELAPSED : (r < 95) ? KIND_SET : KIND_STOP;
    else
      k = (r < 72) ? KIND_ELAPSED : (r < 90) ? KIND_SET : (r < 96) ? KIND_START : KIND_STOP;
    sel = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_CHANNELS, 31)
                                      : $urandom_range(0, NUM_CHANNELS - 1);
    case ($urandom_range(0, 5))
      0: val = $urandom_range(0, 4095);
      1: begin
        case ($urandom_range(0, 3))
          0: val = 800;
          1: val = 801;
          2: val = int'(slot_len) - 1;
          default: val = int'(slot_len);
        endcase
        if (val < 0) val = 0;
      end
      default: val = (slot_len > 802) ? $urandom_range(801, int'(slot_len) - 1)
                                      : $urandom_range(0, 4095);
    endcase
  endtask

  initial begin : timeout
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    kind_e k;
    int    sel;
    int    val;
    int    cnt;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_ACTIVE;
    cfg_data_i           = '0;
    in_if.valid          = 1'b0;
    in_if.kind           = KIND_SET;
    in_if.channel_select = '0;
    in_if.channel_value  = '0;
    typed_armed          = 1'b0;
    typed_word           = '0;
    idle_on              = 1'b1;
    hold_req             = 1'b0;
    error_count          = 0;
    foreach (chan_period[i]) chan_period[i] = RESET_VALUE;
    next_slot   = 0;
    frame_total = 0;
    gap_pending = 1'b0;
    seq_running = 1'b0;
    act_count   = ACT_RESET;
    slot_len    = SLOT_RESET;
    sync_len    = SYNC_RESET;
    pulse_w     = PULSE_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, value bounds and ignored slots.
    add_checked(KIND_START, mk_word(4500, 0, 1'b1, 0));
    add_event(KIND_SET, 1, 801);
    add_event(KIND_SET, 2, 800);
    add_event(KIND_SET, 3, 2199);
    add_event(KIND_SET, 4, 2200);
    add_event(KIND_SET, 16, 1000);
    add_event(KIND_SET, 31, 4095);
    add_checked(KIND_ELAPSED, mk_word(1500, 300, 1'b0, 0));
    add_checked(KIND_ELAPSED, mk_word(801, 300, 1'b0, 1));
    add_checked(KIND_ELAPSED, mk_word(1500, 300, 1'b0, 2));
    add_checked(KIND_ELAPSED, mk_word(2199, 300, 1'b0, 3));
    add_checked(KIND_ELAPSED, mk_word(1500, 300, 1'b0, 4));
    add_event(KIND_STOP, 0, 0);
    add_event(KIND_ELAPSED, 0, 0);
    // No active channels: the closing gap follows the sync at once.
    add_reg(CFG_ACTIVE, 0);
    add_checked(KIND_START, mk_word(4500, 0, 1'b1, 0));
    add_checked(KIND_ELAPSED, mk_word(4500, 300, 1'b1, 0));
    // Slot length lowered mid-frame: the gap cannot go below zero.
    add_reg(CFG_ACTIVE, 1);
    add_reg(CFG_SYNC, 1);
    add_reg(CFG_PULSE, 4095);
    add_checked(KIND_START, mk_word(1, 0, 1'b1, 0));
    add_checked(KIND_ELAPSED, mk_word(1500, 4095, 1'b0, 0));
    add_reg(CFG_SLOT, 1);
    add_checked(KIND_ELAPSED, mk_word(0, 4095, 1'b1, 0));
    add_event(KIND_SET, 5, 801);
    // Count above the table size, largest slot and sync lengths.
    add_reg(CFG_ACTIVE, 31);
    add_reg(CFG_SLOT, 4095);
    add_reg(CFG_SYNC, 8191);
    add_reg(CFG_PULSE, 0);
    add_event(KIND_SET, 15, 4094);
    add_checked(KIND_START, mk_word(8191, 0, 1'b1, 0));
    add_checked(KIND_ELAPSED, mk_word(1500, 0, 1'b0, 0));

    foreach (steps[i]) begin
      if (steps[i].reg_write) write_reg(steps[i].reg_idx, steps[i].reg_data);
      else send_word(steps[i].kind, steps[i].sel, steps[i].val, steps[i].typed,
                     steps[i].word);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      configure_phase(phase);
      idle_on = (phase != PHASES - 1) && (phase % 3 != 2);
      cnt = 0;
      while (cnt < ITEMS_PER_PHASE) begin
        random_event(k, sel, val);
        if (!(k == KIND_ELAPSED && !seq_running)) cnt++;
        if (phase == HOLD_PHASE && cnt == 10) hold_req = 1'b1;
        send_word(k, sel, val, 1'b0, '0);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
